/* rtl/bed_pkg.sv */
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types, character codes and helpers for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

    localparam int BED_QUEUE_DEPTH = 4;
    localparam int BED_MAX_BURST   = 4;

    typedef enum logic [1:0] {
        PH_PLAIN     = 2'd0,
        PH_BACKSLASH = 2'd1,
        PH_X         = 2'd2,
        PH_HEX1      = 2'd3
    } phase_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;

    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_NUL = 8'h00;

    // Up to four decoded bytes caused by one character.
    typedef struct packed {
        logic [BED_MAX_BURST-1:0][7:0] bytes;
        logic [2:0]                    count;
        logic                          last;
    } burst_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) ||
                 (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Letters have bit 6 set; their low nibble is 1..6 for a..f / A..F.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        hex_nibble = c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

    // Append one byte; drop it once the burst is full.
    function automatic burst_t burst_put(input burst_t b, input logic [7:0] v);
        burst_t r;
        r = b;
        if (b.count < 3'(BED_MAX_BURST))
        begin
            r.bytes[b.count[1:0]] = v;
            r.count               = b.count + 3'd1;
        end
        burst_put = r;
    endfunction

endpackage

/* rtl/bed_char_if.sv */
// ----------------------------------------------------------------------------
// bed_char_if
// Character channel: one text character and its end-of-text mark per beat.
// ----------------------------------------------------------------------------
interface bed_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

/* rtl/bed_byte_if.sv */
// ----------------------------------------------------------------------------
// bed_byte_if
// Byte channel: one decoded byte and its last-of-text mark per beat.
// ----------------------------------------------------------------------------
interface bed_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

/* rtl/bed_front.sv */
// ----------------------------------------------------------------------------
// bed_front
// Escape state machine: classifies each accepted character and forms the
// burst of decoded bytes it causes.
// ----------------------------------------------------------------------------
module bed_front
    import bed_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     char_code,
    input  logic           end_of_text,
    output logic           push,
    output burst_t         burst
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            held_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    always_comb
    begin
        burst_t b;
        b          = '0;
        phase_next = phase_reg;
        held_next  = held_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_PLAIN:
                begin
                    if (char_code == CH_BACKSLASH)
                        phase_next = PH_BACKSLASH;
                    else
                        b = burst_put(b, char_code);
                end
                PH_BACKSLASH:
                begin
                    phase_next = PH_PLAIN;
                    unique case (char_code)
                        CH_BACKSLASH: b = burst_put(b, CH_BACKSLASH);
                        CH_LOWER_R:   b = burst_put(b, BYTE_CR);
                        CH_LOWER_N:   b = burst_put(b, BYTE_LF);
                        CH_LOWER_T:   b = burst_put(b, BYTE_TAB);
                        CH_DIGIT_0:   b = burst_put(b, BYTE_NUL);
                        CH_LOWER_X:   phase_next = PH_X;
                        default:
                        begin
                            b = burst_put(b, CH_BACKSLASH);
                            b = burst_put(b, char_code);
                        end
                    endcase
                end
                PH_X:
                begin
                    if (is_hex(char_code))
                    begin
                        held_next  = char_code;
                        phase_next = PH_HEX1;
                    end
                    else
                    begin
                        b = burst_put(b, CH_BACKSLASH);
                        b = burst_put(b, CH_LOWER_X);
                        // replay the character as plain text
                        if (char_code == CH_BACKSLASH)
                            phase_next = PH_BACKSLASH;
                        else
                        begin
                            b          = burst_put(b, char_code);
                            phase_next = PH_PLAIN;
                        end
                    end
                end
                PH_HEX1:
                begin
                    if (is_hex(char_code))
                    begin
                        b = burst_put(b, {hex_nibble(held_reg), hex_nibble(char_code)});
                        phase_next = PH_PLAIN;
                    end
                    else
                    begin
                        b = burst_put(b, CH_BACKSLASH);
                        b = burst_put(b, CH_LOWER_X);
                        b = burst_put(b, held_reg);
                        if (char_code == CH_BACKSLASH)
                            phase_next = PH_BACKSLASH;
                        else
                        begin
                            b          = burst_put(b, char_code);
                            phase_next = PH_PLAIN;
                        end
                    end
                    held_next = '0;
                end
                default:
                begin
                    phase_next = PH_PLAIN;
                end
            endcase

            // flush a pending escape literally at the end of the text
            if (end_of_text)
            begin
                unique case (phase_next)
                    PH_BACKSLASH:
                    begin
                        b = burst_put(b, CH_BACKSLASH);
                    end
                    PH_X:
                    begin
                        b = burst_put(b, CH_BACKSLASH);
                        b = burst_put(b, CH_LOWER_X);
                    end
                    PH_HEX1:
                    begin
                        b = burst_put(b, CH_BACKSLASH);
                        b = burst_put(b, CH_LOWER_X);
                        b = burst_put(b, held_next);
                    end
                    default:
                    begin
                    end
                endcase
                phase_next = PH_PLAIN;
                held_next  = '0;
            end
            b.last = end_of_text;
        end

        burst = b;
        push  = accept && (b.count != 3'd0);
    end

endmodule

/* rtl/bed_queue.sv */
// ----------------------------------------------------------------------------
// bed_queue
// Short FIFO of decoded bursts between the escape state machine and the
// byte serializer.
// ----------------------------------------------------------------------------
module bed_queue
    import bed_pkg::*;
#(
    parameter int DEPTH = BED_QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  burst_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output burst_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    burst_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        case ({push, pop})
            2'b10:   fill_next = fill_reg + CNT_W'(1);
            2'b01:   fill_next = fill_reg - CNT_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/bed_back.sv */
// ----------------------------------------------------------------------------
// bed_back
// Byte serializer: walks the head burst one byte per beat into the output
// register.
// ----------------------------------------------------------------------------
module bed_back
    import bed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  burst_t     head,
    output logic       pop,
    bed_byte_if.source decoded
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       final_beat;

    assign load       = head_valid && (!out_valid_reg || decoded.ready);
    assign final_beat = (({1'b0, idx_reg} + 3'd1) == head.count);
    assign pop        = load && final_beat;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = final_beat ? 2'd0 : idx_reg + 2'd1;
        end
        else if (decoded.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the beat until it is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= head.last && final_beat;
        end
    end

    assign decoded.valid      = out_valid_reg;
    assign decoded.byte_value = byte_reg;
    assign decoded.last_byte  = last_reg;

endmodule

/* rtl/backslash_escape_decoder_core.sv */
// ----------------------------------------------------------------------------
// backslash_escape_decoder_core
// Decodes C-style backslash escapes in a Latin-1 character stream. One
// character is accepted per cycle while the burst queue (QUEUE_DEPTH entries)
// has room; each character yields zero to four bytes, which leave through the
// output register at one byte per cycle while the receiver is ready. Each
// burst is written into the queue and then loaded byte by byte into the
// output register. Backslash followed by \ r n t 0 gives the control byte,
// backslash-x with two hex digits gives that byte, anything else is passed
// literally, and a pending escape is flushed when the text ends; last_byte
// marks the final byte of every text.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_core
    import bed_pkg::*;
#(
    parameter int QUEUE_DEPTH = BED_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    bed_char_if.sink   text,
    bed_byte_if.source decoded
);

    logic   accept;
    logic   push;
    logic   full;
    logic   pop;
    logic   head_valid;
    burst_t burst;
    burst_t head;

    assign text.ready = !full;
    assign accept     = text.valid && !full;

    bed_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (text.char_code),
        .end_of_text (text.end_of_text),
        .push        (push),
        .burst       (burst)
    );

    bed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (burst),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    bed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .decoded    (decoded)
    );

endmodule

/* test/bed_decode_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_decode_checker
// Watches the character and byte channels of the escape decoder, decodes
// every accepted character on its own and compares each byte beat, in
// order, with the oldest decoded byte still outstanding.
// ----------------------------------------------------------------------------
module bed_decode_checker
    import bed_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bed_char_if  text,
    bed_byte_if  decoded,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } dec_byte_t;

    dec_byte_t  expected_bytes[$];
    dec_byte_t  oldest;
    phase_t     esc_phase;
    logic [7:0] held_digit;
    logic [7:0] burst[4];
    int         burst_len;

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'(8'h30);
        if (c >= "a" && c <= "f")
            return int'(c) - int'(8'h61) + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'(8'h41) + 10;
        return -1;
    endfunction

    // Append one byte to the tail of the expected stream.
    function void queue_expected(input logic [7:0] v, input logic last);
        dec_byte_t nb;
        nb.value       = v;
        nb.last        = last;
        expected_bytes = {expected_bytes, nb};
    endfunction

    // Drop anything beyond four bytes per character.
    function void add_byte(input logic [7:0] v);
        if (burst_len < 4)
        begin
            burst[burst_len] = v;
            burst_len++;
        end
    endfunction

    function void plain_char(input logic [7:0] c);
        if (c == CH_BACKSLASH)
            esc_phase = PH_BACKSLASH;
        else
        begin
            add_byte(c);
            esc_phase = PH_PLAIN;
        end
    endfunction

    function void decode_char(input logic [7:0] c, input logic eot);
        burst_len = 0;
        case (esc_phase)
            PH_PLAIN:
                plain_char(c);
            PH_BACKSLASH:
            begin
                esc_phase = PH_PLAIN;
                if (c == CH_BACKSLASH)
                    add_byte(CH_BACKSLASH);
                else if (c == CH_LOWER_R)
                    add_byte(BYTE_CR);
                else if (c == CH_LOWER_N)
                    add_byte(BYTE_LF);
                else if (c == CH_LOWER_T)
                    add_byte(BYTE_TAB);
                else if (c == CH_DIGIT_0)
                    add_byte(BYTE_NUL);
                else if (c == CH_LOWER_X)
                    esc_phase = PH_X;
                else
                begin
                    add_byte(CH_BACKSLASH);
                    add_byte(c);
                end
            end
            PH_X:
            begin
                if (digit_value(c) >= 0)
                begin
                    held_digit = c;
                    esc_phase  = PH_HEX1;
                end
                else
                begin
                    add_byte(CH_BACKSLASH);
                    add_byte(CH_LOWER_X);
                    plain_char(c);
                end
            end
            default:
            begin
                if (digit_value(c) >= 0)
                begin
                    add_byte(8'(digit_value(held_digit) * 16 + digit_value(c)));
                    esc_phase = PH_PLAIN;
                end
                else
                begin
                    add_byte(CH_BACKSLASH);
                    add_byte(CH_LOWER_X);
                    add_byte(held_digit);
                    plain_char(c);
                end
                held_digit = 8'h00;
            end
        endcase

        // Flush a pending escape literally at the end of the text.
        if (eot)
        begin
            if (esc_phase == PH_BACKSLASH)
                add_byte(CH_BACKSLASH);
            else if (esc_phase == PH_X)
            begin
                add_byte(CH_BACKSLASH);
                add_byte(CH_LOWER_X);
            end
            else if (esc_phase == PH_HEX1)
            begin
                add_byte(CH_BACKSLASH);
                add_byte(CH_LOWER_X);
                add_byte(held_digit);
            end
            esc_phase  = PH_PLAIN;
            held_digit = 8'h00;
        end

        for (int i = 0; i < burst_len; i++)
            queue_expected(burst[i], eot && (i == burst_len - 1));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_phase  = PH_PLAIN;
            held_digit = 8'h00;
            fail_count = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (text.valid && text.ready)
                decode_char(text.char_code, text.end_of_text);

            if (decoded.valid && decoded.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected byte beat: byte_value %h last_byte %b",
                           decoded.byte_value, decoded.last_byte);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_bytes.pop_front();
                    if (decoded.byte_value !== oldest.value)
                    begin
                        $error("byte_value: expected %h, actual %h",
                               oldest.value, decoded.byte_value);
                        fail_count++;
                    end
                    if (decoded.last_byte !== oldest.last)
                    begin
                        $error("last_byte: expected %b, actual %b",
                               oldest.last, decoded.last_byte);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_bytes.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives texts of escaped characters into the decoder under several idle and
// stall patterns, including a long output hold-off, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top
    import bed_pkg::*;
();

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    int         fail_count;
    int         pending;
    int         src_idle_pct  = 0;
    int         snk_stall_pct = 0;
    bit         hold_off_req  = 1'b0;
    int         chars_sent    = 0;
    logic [7:0] text_buf[$];

    bed_char_if text_ch();
    bed_byte_if byte_ch();

    always #5 clk = ~clk;

    backslash_escape_decoder_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_ch),
        .decoded (byte_ch)
    );

    bed_decode_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text_ch),
        .decoded    (byte_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one character; return after the edge that accepts it.
    task automatic send_char(input logic [7:0] c, input logic eot);
        bit taken;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.char_code   <= c;
        text_ch.end_of_text <= eot;
        do
        begin
            @(negedge clk);
            taken = text_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        chars_sent++;
    endtask

    task automatic send_str(input string s, input logic eot_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], eot_last && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] rand_hex_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    // Append one character to the text being built.
    function automatic void add_text_char(input logic [7:0] ch);
        text_buf = {text_buf, ch};
    endfunction

    // Append one well-formed escape, one broken escape or one plain character.
    task automatic queue_token();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        c    = 8'($urandom_range(0, 255));
        if (pick < 30)
            add_text_char(c);
        else if (pick < 50)
        begin
            add_text_char(CH_BACKSLASH);
            case ($urandom_range(0, 4))
                0: add_text_char(CH_BACKSLASH);
                1: add_text_char(CH_LOWER_R);
                2: add_text_char(CH_LOWER_N);
                3: add_text_char(CH_LOWER_T);
                default: add_text_char(CH_DIGIT_0);
            endcase
        end
        else if (pick < 75)
        begin
            add_text_char(CH_BACKSLASH);
            add_text_char(CH_LOWER_X);
            add_text_char(rand_hex_digit());
            add_text_char(rand_hex_digit());
        end
        else if (pick < 83)
        begin
            add_text_char(CH_BACKSLASH);
            add_text_char(c);
        end
        else if (pick < 90)
        begin
            add_text_char(CH_BACKSLASH);
            add_text_char(CH_LOWER_X);
            add_text_char(c);
        end
        else if (pick < 96)
        begin
            add_text_char(CH_BACKSLASH);
            add_text_char(CH_LOWER_X);
            add_text_char(rand_hex_digit());
            add_text_char(c);
        end
        else
            add_text_char(CH_BACKSLASH);
    endtask

    task automatic send_random_text();
        int n_tokens;
        n_tokens = $urandom_range(1, 6);
        repeat (n_tokens)
            queue_token();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    // Receiver: random stalls, or one long hold-off when requested.
    initial
    begin
        byte_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                byte_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
                byte_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    initial
    begin
        text_ch.valid       <= 1'b0;
        text_ch.char_code   <= 8'h00;
        text_ch.end_of_text <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, every escape letter, both hex cases, broken escapes
        // and texts that end inside an escape.
        send_char(8'h00, 1'b0);
        send_str("\\\\\\r\\n\\t\\0", 1'b0);
        send_str("\\xfF\\q\\xg", 1'b0);
        send_str("\\x4\\", 1'b1);
        send_str("\\x", 1'b1);
        send_str("\\", 1'b1);
        send_char(8'hFF, 1'b1);

        for (int idle_phase = 0; idle_phase < 5; idle_phase++)
        begin
            case (idle_phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 56; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 56; end
                3: begin src_idle_pct = 13; snk_stall_pct = 13; end
                default:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                    hold_off_req  = 1'b1;
                end
            endcase
            while (chars_sent < 28 + (idle_phase + 1) * 48)
                send_random_text();
        end
        text_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/bed_pkg.sv
rtl/bed_char_if.sv
rtl/bed_byte_if.sv
rtl/bed_front.sv
rtl/bed_queue.sv
rtl/bed_back.sv
rtl/backslash_escape_decoder_core.sv
test/bed_decode_checker.sv
test/tb_top.sv
